[hw/rtl/mhpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue: request and
// status codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W  = 32;
    localparam int CAP_W  = 11;
    localparam int IDX_W  = 10;
    localparam int TYPE_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INS_START,
        OP_REM_READ,
        OP_REM_LOAD,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_PLACE,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_SCAN_START,
        OP_SCAN_READ,
        OP_SCAN_NEXT,
        OP_SCAN_HIT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHECK,
        S_UP_CMP,
        S_REM_LOAD,
        S_DN_CHECK,
        S_DN_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_POST
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_res;
        status_t res_status;
        logic    post;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic count_one;
        logic at_root;
        logic up_move;
        logic has_child;
        logic dn_move;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

[hw/rtl/mhpq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_if
// Channel interfaces of the max-heap priority queue: request, result and
// capacity write, each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface mhpq_req_if import mhpq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic signed [KEY_W-1:0]  key_value;

    modport source (output valid, output req_type, output key_value, input ready);
    modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    status_t                  status;
    logic signed [KEY_W-1:0]  removed_key;
    logic [IDX_W-1:0]         found_index;

    modport source (output valid, output status, output removed_key,
                    output found_index, input ready);
    modport sink   (input valid, input status, input removed_key,
                    input found_index, output ready);
endinterface

interface mhpq_cfg_if import mhpq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

[hw/rtl/mhpq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Request sequencer: decodes each request and steps the datapath through
// sift-up, sift-down or a linear search, then posts the result.
// ----------------------------------------------------------------------------
module mhpq_ctrl import mhpq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [TYPE_W-1:0] req_type,
    output logic              req_ready,
    input  dp_stat_t          stat,
    output dp_cmd_t           cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.set_res    = 1'b0;
        cmd.res_status = STATUS_OK;
        cmd.post       = 1'b0;
        req_ready      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_POST;
                    case (req_type)
                        REQ_INSERT:
                        begin
                            if (stat.full)
                            begin
                                cmd.res_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.op     = OP_INS_START;
                                state_next = S_UP_CHECK;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = OP_REM_READ;
                                state_next = S_REM_LOAD;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.res_status = STATUS_NOT_FOUND;
                                cmd.op         = OP_SCAN_START;
                                state_next     = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            cmd.res_status = STATUS_OK;
                        end
                    endcase
                end
            end
            S_UP_CHECK:
            begin
                if (stat.at_root)
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_POST;
                end
                else
                begin
                    cmd.op     = OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_move)
                begin
                    cmd.op     = OP_UP_MOVE;
                    state_next = S_UP_CHECK;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_POST;
                end
            end
            S_REM_LOAD:
            begin
                cmd.op = OP_REM_LOAD;
                if (stat.count_one)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    state_next = S_DN_CHECK;
                end
            end
            S_DN_CHECK:
            begin
                if (stat.has_child)
                begin
                    cmd.op     = OP_DN_READ;
                    state_next = S_DN_CMP;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_POST;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_move)
                begin
                    cmd.op     = OP_DN_MOVE;
                    state_next = S_DN_CHECK;
                end
                else
                begin
                    cmd.op     = OP_PLACE;
                    state_next = S_POST;
                end
            end
            S_SCAN_RD:
            begin
                cmd.op     = OP_SCAN_READ;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.scan_hit)
                begin
                    cmd.op     = OP_SCAN_HIT;
                    state_next = S_POST;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/mhpq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap memory with two registered read ports, entry count, moving key and
// hole index, capacity register, result fields and the output register.
// ----------------------------------------------------------------------------
module mhpq_datapath import mhpq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [KEY_W-1:0] key_value,
    mhpq_cfg_if.sink                cfg,
    mhpq_rsp_if.source              rsp,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    logic signed [KEY_W-1:0] heap_mem [DEPTH];

    logic [CAP_W-1:0]        capacity_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           hole_reg;
    logic [AW-1:0]           hole_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [KEY_W-1:0] rd_a_reg;
    logic signed [KEY_W-1:0] rd_b_reg;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic                    mem_we;
    logic signed [KEY_W-1:0] mem_wdata;

    status_t                 res_status_reg;
    logic signed [KEY_W-1:0] res_removed_reg;
    logic [IDX_W-1:0]        res_index_reg;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic signed [KEY_W-1:0] out_removed_reg;
    logic [IDX_W-1:0]        out_index_reg;

    logic [AW-1:0]           parent_idx;
    logic [XW-1:0]           left_idx;
    logic [XW-1:0]           right_idx;
    logic                    right_valid;
    logic                    take_right;
    logic signed [KEY_W-1:0] child_val;
    logic [AW-1:0]           child_idx;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            capacity_reg <= cfg.capacity;
        end
    end

    assign parent_idx  = (hole_reg - AW'(1)) >> 1;
    assign left_idx    = {1'b0, hole_reg, 1'b1};
    assign right_idx   = {1'b0, hole_reg, 1'b0} + XW'(2);
    assign right_valid = right_idx < XW'(count_reg);
    assign take_right  = right_valid && (rd_b_reg > rd_a_reg);
    assign child_val   = take_right ? rd_b_reg : rd_a_reg;
    assign child_idx   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    assign stat.full      = (LW'(count_reg) >= LW'(capacity_reg)) ||
                            (LW'(count_reg) >= LW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.count_one = (count_reg == CW'(1));
    assign stat.at_root   = (hole_reg == '0);
    assign stat.up_move   = (key_reg > rd_a_reg);
    assign stat.has_child = (left_idx < XW'(count_reg));
    assign stat.dn_move   = (child_val > key_reg);
    assign stat.scan_hit  = (rd_a_reg == key_reg);
    assign stat.scan_last = ((CW'(hole_reg) + CW'(1)) == count_reg);
    assign stat.out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        mem_we    = 1'b0;
        mem_wdata = key_reg;
        count_next = count_reg;
        hole_next  = hole_reg;
        key_next   = key_reg;
        case (cmd.op)
            OP_INS_START:
            begin
                key_next   = key_value;
                hole_next  = AW'(count_reg);
                count_next = count_reg + CW'(1);
            end
            OP_REM_READ:
            begin
                rd_addr_b = AW'(count_reg - CW'(1));
            end
            OP_REM_LOAD:
            begin
                key_next   = rd_b_reg;
                hole_next  = '0;
                count_next = count_reg - CW'(1);
            end
            OP_UP_READ:
            begin
                rd_addr_a = parent_idx;
            end
            OP_UP_MOVE:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_a_reg;
                hole_next = parent_idx;
            end
            OP_PLACE:
            begin
                mem_we = 1'b1;
            end
            OP_DN_READ:
            begin
                rd_addr_a = left_idx[AW-1:0];
                rd_addr_b = right_idx[AW-1:0];
            end
            OP_DN_MOVE:
            begin
                mem_we    = 1'b1;
                mem_wdata = child_val;
                hole_next = child_idx;
            end
            OP_SCAN_START:
            begin
                key_next  = key_value;
                hole_next = '0;
            end
            OP_SCAN_READ:
            begin
                rd_addr_a = hole_reg;
            end
            OP_SCAN_NEXT:
            begin
                hole_next = hole_reg + AW'(1);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[hole_reg] <= mem_wdata;
        end
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        key_reg  <= key_next;
        if (cmd.set_res)
        begin
            res_status_reg  <= cmd.res_status;
            res_removed_reg <= '0;
            res_index_reg   <= '0;
        end
        else if (cmd.op == OP_REM_LOAD)
        begin
            res_removed_reg <= rd_a_reg;
        end
        else if (cmd.op == OP_SCAN_HIT)
        begin
            res_status_reg <= STATUS_OK;
            res_index_reg  <= IDX_W'(hole_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            out_status_reg  <= res_status_reg;
            out_removed_reg <= res_removed_reg;
            out_index_reg   <= res_index_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.removed_key = out_removed_reg;
    assign rsp.found_index = out_index_reg;

endmodule

[hw/rtl/max_heap_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap of signed 32-bit keys with insert, remove-maximum and
// search requests, one result per request.
//
//   channel  dir  payload                                  
//   req      in   req_type, key_value                      
//   rsp      out  status, removed_key, found_index         
//   cfg      in   capacity (always ready)                  
//
// Insert puts the key in a new hole at the end and sifts it up a level at a
// time, stopping at the root or below a parent that is not smaller.
// Remove takes the root and, unless that was the last key, moves the last key
// to the root and sifts it down until no child is larger.
// Search scans the entries in order; full, empty and unused requests go straight to post.
// All steps share the single heap memory.
// A request is taken only in idle; a result waits in the output register
// while the next request runs, and a stalled rsp holds the block in post.
// Reset empties the heap at once; no clearing pass.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit import mhpq_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp,
    mhpq_cfg_if.sink   cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mhpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mhpq_datapath
    #(
        .DEPTH (DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_value (req.key_value),
        .cfg       (cfg),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[hw/rtl/mhpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the max-heap priority queue: result hold, request
// pacing and request/result balance.
// ----------------------------------------------------------------------------
module mhpq_checker import mhpq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [1:0]              rsp_status,
    input logic signed [KEY_W-1:0] rsp_removed_key,
    input logic [IDX_W-1:0]        rsp_found_index
);

    logic [1:0] open_reg;
    logic [1:0] open_next;

    always_comb
    begin
        open_next = open_reg;
        if (req_valid && req_ready)
        begin
            open_next = open_next + 2'd1;
        end
        if (rsp_valid && rsp_ready)
        begin
            open_next = open_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_removed_key) && $stable(rsp_found_index))
        else $error("result changed while stalled");

    a_req_pace: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_rsp_owed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 2'd0)
        else $error("result without request");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("too many requests in flight");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_removed_key (rsp.removed_key),
    .rsp_found_index (rsp.found_index)
);
